@@ design/ula_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ula_pkg
// Shared constants and controller/datapath interface types for the
// serial line assembler.
// ----------------------------------------------------------------------------
package ula_pkg;

    localparam int LINE_BUFFER_BYTES = 64;
    localparam int STORE_DEPTH       = 64;
    localparam int IDX_W             = $clog2(STORE_DEPTH);

    localparam logic [7:0] BYTE_CR  = 8'h0D;
    localparam logic [7:0] BYTE_LF  = 8'h0A;
    localparam logic [7:0] BYTE_NUL = 8'h00;

    localparam logic [1:0] KIND_ECHO     = 2'd0;
    localparam logic [1:0] KIND_LINE     = 2'd1;
    localparam logic [1:0] KIND_OVERFLOW = 2'd2;

    typedef struct packed {
        logic accept;     // input beat taken, echo loaded
        logic load_line;  // next stored byte to result register
        logic load_ovf;   // overflow result to result register
    } ula_cmd_t;

    typedef struct packed {
        logic slot_free;  // result register empty or draining this cycle
        logic is_full;    // no free slot for the incoming byte
        logic is_term;    // incoming byte is a line terminator
        logic line_end;   // read pointer sits on the last byte of the line
    } ula_stat_t;

endpackage : ula_pkg
`default_nettype wire

@@ design/ula_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ula_ctrl
// Controller: sequences echo, line readout and overflow results.
// ----------------------------------------------------------------------------
module ula_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               rx_valid,
    output logic                    rx_ready,
    input  wire ula_pkg::ula_stat_t stat,
    output ula_pkg::ula_cmd_t       cmd
);
    import ula_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_PRIME = 2'd1;
    localparam logic [1:0] ST_LINE  = 2'd2;
    localparam logic [1:0] ST_OVF   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign rx_ready = (state_reg == ST_IDLE) && stat.slot_free;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.load_line = 1'b0;
        cmd.load_ovf  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (rx_valid && stat.slot_free)
                begin
                    cmd.accept = 1'b1;
                    if (stat.is_full)
                        state_next = ST_OVF;
                    else if (stat.is_term)
                        state_next = ST_PRIME;
                end
            end
            // first read of the store lands in the cycle after the write
            ST_PRIME:
            begin
                state_next = ST_LINE;
            end
            ST_LINE:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_line = 1'b1;
                    if (stat.line_end)
                        state_next = ST_IDLE;
                end
            end
            ST_OVF:
            begin
                if (stat.slot_free)
                begin
                    cmd.load_ovf = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule : ula_ctrl
`default_nettype wire

@@ design/ula_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ula_dp
// Datapath: line store, fill index, read pointer and result register.
// ----------------------------------------------------------------------------
module ula_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [7:0]        rx_byte,
    input  wire ula_pkg::ula_cmd_t cmd,
    output ula_pkg::ula_stat_t     stat,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output logic [1:0]             kind,
    output logic [7:0]             data_byte,
    output logic [5:0]             line_length,
    output logic                   last
);
    import ula_pkg::*;

    localparam logic [IDX_W-1:0] FULL_LEVEL = IDX_W'(LINE_BUFFER_BYTES - 1);

    logic [7:0]       store_mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [IDX_W-1:0] rd_addr;

    logic [IDX_W-1:0] fill_idx_reg;
    logic [IDX_W-1:0] fill_idx_next;
    logic [IDX_W-1:0] len_reg;
    logic [IDX_W-1:0] len_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic [IDX_W-1:0] ptr_inc;

    logic             res_valid_reg;
    logic [1:0]       kind_reg;
    logic [7:0]       data_reg;
    logic [5:0]       length_reg;
    logic             last_reg;

    assign ptr_inc = ptr_reg + 1'b1;

    assign stat.slot_free = !res_valid_reg || res_ready;
    assign stat.is_full   = (fill_idx_reg >= FULL_LEVEL);
    assign stat.is_term   = (rx_byte == BYTE_CR) || (rx_byte == BYTE_LF);
    assign stat.line_end  = (ptr_inc == len_reg);

    always_comb
    begin
        fill_idx_next = fill_idx_reg;
        len_next      = len_reg;
        ptr_next      = ptr_reg;
        if (cmd.accept)
        begin
            ptr_next = '0;
            if (stat.is_full)
                fill_idx_next = '0;
            else if (stat.is_term)
            begin
                fill_idx_next = '0;
                len_next      = fill_idx_reg + 1'b1;
            end
            else
                fill_idx_next = fill_idx_reg + 1'b1;
        end
        else if (cmd.load_line)
            ptr_next = ptr_inc;
    end

    // read pointer moves ahead so the next byte is ready when the slot frees
    assign rd_addr = ptr_next;

    always_ff @(posedge clk)
    begin
        if (cmd.accept && !stat.is_full)
            store_mem[fill_idx_reg] <= rx_byte;
        rd_data_reg <= store_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_idx_reg  <= '0;
            len_reg       <= '0;
            ptr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            fill_idx_reg <= fill_idx_next;
            len_reg      <= len_next;
            ptr_reg      <= ptr_next;
            if (cmd.accept || cmd.load_line || cmd.load_ovf)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg   <= KIND_ECHO;
            data_reg   <= rx_byte;
            length_reg <= '0;
            last_reg   <= !stat.is_full && !stat.is_term;
        end
        else if (cmd.load_line)
        begin
            kind_reg   <= KIND_LINE;
            data_reg   <= rd_data_reg;
            length_reg <= 6'(len_reg);
            last_reg   <= stat.line_end;
        end
        else if (cmd.load_ovf)
        begin
            kind_reg   <= KIND_OVERFLOW;
            data_reg   <= BYTE_NUL;
            length_reg <= '0;
            last_reg   <= 1'b1;
        end
    end

    assign res_valid   = res_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign line_length = length_reg;
    assign last        = last_reg;

endmodule : ula_dp
`default_nettype wire

@@ design/uart_line_assembler.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uart_line_assembler
// Receive-side line assembler: echoes each byte, collects a line and
// replays it on a terminator, reports overflow when the store is full.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  rx      | rx_valid / rx_ready  | rx_byte
//  res     | res_valid / res_ready| kind, data_byte, line_length, last
//
//  rx_ready is high while the sequencer is idle and the result register is
//  empty or being drained, so ordinary bytes can follow back to back. a
//  terminator replays the line (63 bytes at most) from one store read port,
//  one line byte per cycle while res_ready does not stall it, after a read prime.
//  an overflow adds an overflow result; res_ready low stalls the sequencer in place.
//  reset clears the fill index and sequencer; the store itself is not cleared.
// ----------------------------------------------------------------------------
module uart_line_assembler (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_ready,
    input  wire logic [7:0] rx_byte,
    output logic            res_valid,
    input  wire logic       res_ready,
    output logic [1:0]      kind,
    output logic [7:0]      data_byte,
    output logic [5:0]      line_length,
    output logic            last
);
    import ula_pkg::*;

    ula_cmd_t  cmd;
    ula_stat_t stat;

    ula_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ula_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .cmd         (cmd),
        .stat        (stat),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .line_length (line_length),
        .last        (last)
    );

    // only one result source loads the result register per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.accept, cmd.load_line, cmd.load_ovf}))
        else $error("result register loaded from two sources");

    // a byte that finds the store full is followed by a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_valid && rx_ready && stat.is_full) |=> !rx_ready)
        else $error("input taken while overflow result pending");

    // a byte that fills no line ends its results with the echo
    assert property (@(posedge clk) disable iff (!rst_n)
        (rx_valid && rx_ready && !stat.is_full && !stat.is_term) |=>
            (res_valid && kind == KIND_ECHO && last))
        else $error("plain byte echo not flagged as last");

    // line results always carry a nonzero length
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && kind == KIND_LINE) |-> (line_length != 6'd0))
        else $error("line result with zero length");

endmodule : uart_line_assembler
`default_nettype wire

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the serial line assembler. Bytes go in over the
// rx handshake in random bursts, and the bench keeps its own copy of the
// line store and fill count to work out the echo, line and overflow beats.
// Every result beat is compared field by field, in order, with what was
// predicted. The receiver stalls on its own pattern and once holds off
// for a long stretch.
// ----------------------------------------------------------------------------
module tb_top;
    import ula_pkg::*;

    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_BYTES = 140;
    localparam int MAX_REPORTS  = 200;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
        logic [5:0] len;
        logic       last;
    } line_beat_t;

    typedef enum int {
        STALL_NONE,
        STALL_HALF,
        STALL_LIGHT,
        STALL_HEAVY
    } stall_mode_t;

    class echo_line_tracker;
        logic [7:0]  held_bytes [LINE_BUFFER_BYTES];
        int unsigned fill_count;
        line_beat_t  expected_beats [$];
        int          errors;

        function new();
            fill_count = 0;
            errors = 0;
        endfunction

        function void push_beat(logic [1:0] k, logic [7:0] d, logic [5:0] n, logic l);
            line_beat_t b;
            b.kind = k;
            b.data = d;
            b.len  = n;
            b.last = l;
            expected_beats.push_back(b);
        endfunction

        // one accepted rx beat: echo first, then a whole line or an overflow where one is due
        function void note_rx_byte(logic [7:0] rx);
            int unsigned line_len;
            if (fill_count < LINE_BUFFER_BYTES - 1)
            begin
                held_bytes[fill_count] = rx;
                line_len = fill_count + 1;
                if (rx == BYTE_CR || rx == BYTE_LF)
                begin
                    push_beat(KIND_ECHO, rx, 6'd0, 1'b0);
                    for (int i = 0; i < line_len; i++)
                        push_beat(KIND_LINE, held_bytes[i], 6'(line_len),
                                  i == line_len - 1);
                    fill_count = 0;
                end
                else
                begin
                    fill_count = line_len;
                    push_beat(KIND_ECHO, rx, 6'd0, 1'b1);
                end
            end
            else
            begin
                // store full: byte is echoed but dropped, even a terminator
                fill_count = 0;
                push_beat(KIND_ECHO, rx, 6'd0, 1'b0);
                push_beat(KIND_OVERFLOW, BYTE_NUL, 6'd0, 1'b1);
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t mismatch: %s", $time, what);
        endtask

        task check_result(logic [1:0] k, logic [7:0] d, logic [5:0] n, logic l);
            line_beat_t want;
            if (expected_beats.size() == 0)
            begin
                report($sformatf("unexpected beat kind=%0d data=%02h len=%0d last=%0b",
                                 k, d, n, l));
                return;
            end
            want = expected_beats.pop_front();
            if (k !== want.kind)
                report($sformatf("kind %0d, want %0d", k, want.kind));
            if (d !== want.data)
                report($sformatf("data_byte %02h, want %02h", d, want.data));
            if (n !== want.len)
                report($sformatf("line_length %0d, want %0d", n, want.len));
            if (l !== want.last)
                report($sformatf("last %0b, want %0b", l, want.last));
        endtask

        function int pending();
            return expected_beats.size();
        endfunction
    endclass

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       rx_valid  = 1'b0;
    logic [7:0] rx_byte   = 8'h00;
    logic       res_ready = 1'b0;
    logic       rx_ready;
    logic       res_valid;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic [5:0] line_length;
    logic       last;

    echo_line_tracker tracker = new();
    bit          hold_req   = 1'b0;
    int          burst_left = 0;
    int unsigned bytes_sent = 0;

    uart_line_assembler DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .kind        (kind),
        .data_byte   (data_byte),
        .line_length (line_length),
        .last        (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // sampled before this edge's updates land
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rx_valid && rx_ready)
                tracker.note_rx_byte(rx_byte);
            if (res_valid && res_ready)
                tracker.check_result(kind, data_byte, line_length, last);
        end
    end

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == BYTE_CR || b == BYTE_LF);
        return b;
    endfunction

    // call right after a rising edge; returns right after the accepting edge
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                              : $urandom_range(1, 3);
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!rx_ready);
        bytes_sent++;
    endtask

    task automatic send_line(input int n, input logic [7:0] term);
        repeat (n) send_byte(plain_byte());
        send_byte(term);
    endtask

    task automatic drain_results();
        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        burst_left = 0;
    endtask

    initial
    begin
        int unsigned random_start;
        int pick;
        int n;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field extremes ended by a terminator, then an empty line
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
        // terminator lands in the last free slot: full 63-byte line
        send_line(LINE_BUFFER_BYTES - 2, BYTE_LF);
        // terminator arrives on a full store and is dropped
        send_line(LINE_BUFFER_BYTES - 1, BYTE_CR);
        // ordinary byte on a full store, then a line right after overflow
        send_line(LINE_BUFFER_BYTES - 1, 8'h41);
        send_byte(BYTE_CR);
        drain_results();

        // long receiver hold-off while bytes keep coming
        hold_req = 1'b1;
        burst_left = 200;
        send_line(30, BYTE_CR);
        send_line(5, BYTE_LF);
        drain_results();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, LINE_BUFFER_BYTES - 2)
                                                : $urandom_range(0, 15);
                send_line(n, $urandom_range(0, 1) ? BYTE_CR : BYTE_LF);
            end
            else if (pick < 73)
                send_line(LINE_BUFFER_BYTES - 1, 8'($urandom_range(0, 255)));
            else if (pick < 75)
                drain_results();
            else
                repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)));
        end

        rx_valid <= 1'b0;
        do
            @(posedge clk);
        while (tracker.pending() != 0);
        repeat (200) @(posedge clk);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        stall_mode_t mode;
        int stretch;
        bit take;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                mode = stall_mode_t'($urandom_range(0, 3));
                stretch = $urandom_range(5, 60);
                repeat (stretch)
                begin
                    case (mode)
                        STALL_NONE:  take = 1'b1;
                        STALL_HALF:  take = 1'($urandom_range(0, 1));
                        STALL_LIGHT: take = ($urandom_range(0, 3) != 0);
                        default:     take = ($urandom_range(0, 4) == 0);
                    endcase
                    res_ready <= take;
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin
        #8_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
design/ula_pkg.sv
design/ula_ctrl.sv
design/ula_dp.sv
design/uart_line_assembler.sv
verif/tb_top.sv
